>>> sv/bpft_pkg.sv
// ----------------------------------------------------------------------------
// bpft_pkg: shared types and constants of the bird-view pose frame transform
// Request codes, register set, CORDIC sizing and clipping helpers.
// ----------------------------------------------------------------------------
package bpft_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_W       = $clog2(CORDIC_STAGES);
    localparam int XW            = 34;   // CORDIC x/y, Q2.30 with headroom
    localparam int ZW            = 34;   // CORDIC angle, Q2.30 with headroom

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [XW-1:0] GAIN_Q30  = 34'sd652032874;
    localparam logic signed [21:0] TWO_PI_Q16  = 22'sd411775;
    localparam logic signed [21:0] FOUR_PI_Q16 = 22'sd823550;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

    typedef enum logic [1:0] {
        REQ_CAR_TO_WORLD   = 2'd0,
        REQ_WORLD_TO_CAR   = 2'd1,
        REQ_PIXEL_TO_WORLD = 2'd2,
        REQ_WORLD_TO_PIXEL = 2'd3
    } req_t;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_MPP_X        = 3'd0,
        CFG_MPP_Y        = 3'd1,
        CFG_PPM_X        = 3'd2,
        CFG_PPM_Y        = 3'd3,
        CFG_ORIGIN_X     = 3'd4,
        CFG_ORIGIN_Y     = 3'd5,
        CFG_IMAGE_WIDTH  = 3'd6,
        CFG_IMAGE_HEIGHT = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic        [23:0] mpp_x;
        logic        [23:0] mpp_y;
        logic        [23:0] ppm_x;
        logic        [23:0] ppm_y;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic        [11:0] image_width;
        logic        [11:0] image_height;
    } cfg_t;

    // travels beside the CORDIC angle through the row of cells
    typedef struct packed {
        req_t               req;
        logic signed [23:0] car_x;
        logic signed [23:0] car_y;
        logic signed [24:0] u;
        logic signed [24:0] v;
        logic signed [19:0] yaw;
        logic               beyond;
        logic               satf;
        logic               flip;
    } side_t;

    typedef struct packed {
        logic signed [23:0] res_x;
        logic signed [23:0] res_y;
        logic signed [19:0] res_yaw;
        logic signed [19:0] res_col;
        logic signed [19:0] res_row;
        logic               inside_image;
        logic               row_beyond_image;
        logic               saturated;
    } res_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        return $signed({{(ZW-30){1'b0}}, ATAN_Q30[idx]});
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        logic signed [23:0] r;
        if (v > 40'sd8388607)
            r = 24'sh7fffff;
        else if (v < -40'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [39:0] v);
        logic signed [19:0] r;
        if (v > 40'sd524287)
            r = 20'sh7ffff;
        else if (v < -40'sd524288)
            r = 20'sh80000;
        else
            r = v[19:0];
        return r;
    endfunction

endpackage

>>> sv/birdview_pose_frame_transform.sv
// ----------------------------------------------------------------------------
// birdview_pose_frame_transform: pixel / car / world frame conversion
// Requests on the s_axis channel, one result word per request on m_axis.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per word: tuser is the request kind
//   (car-to-world, world-to-car, pixel-to-world, world-to-pixel), tdata the
//   car pose, point pose and pixel. m_axis returns exactly one result word
//   per request, in order. cfg_we/cfg_index/cfg_data write the scale,
//   origin and image size registers; write them only while no request is
//   in flight.
//   The pipeline runs: capture, yaw fold and pixel scaling, the row of CORDIC
//   cells, rotation products, sums and clipping, pixel products, result
//   register. A new request is taken every cycle while m_axis does not stall;
//   the row of CORDIC cells sets the depth, not the rate.
//   Reset empties the pipeline and loads the register defaults. When m_axis
//   stalls with a word held, the whole pipeline freezes and s_axis_tready
//   drops in the same cycle; it rises again as soon as the word is taken.
// ----------------------------------------------------------------------------
module birdview_pose_frame_transform (
    input  logic         clk,
    input  logic         rst_n,
    // car_x, car_y, car_yaw, point_x, point_y, point_yaw, pixel_x, pixel_y
    input  logic [175:0] s_axis_tdata,
    // req_type
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // res_x, res_y, res_yaw, res_col, res_row, inside_image,
    // row_beyond_image, saturated, zero pad
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    localparam int N = bpft_pkg::CORDIC_STAGES;

    bpft_pkg::cfg_t cfg_reg;
    logic           en;
    logic           out_valid;
    bpft_pkg::res_t res;

    logic                           chain_valid [N+1];
    logic signed [bpft_pkg::XW-1:0] chain_x     [N+1];
    logic signed [bpft_pkg::XW-1:0] chain_y     [N+1];
    logic signed [bpft_pkg::ZW-1:0] chain_z     [N+1];
    bpft_pkg::side_t                chain_side  [N+1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mpp_x        <= 24'd41943;
            cfg_reg.mpp_y        <= 24'd41943;
            cfg_reg.ppm_x        <= 24'd102400;
            cfg_reg.ppm_y        <= 24'd102400;
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.image_width  <= 12'd640;
            cfg_reg.image_height <= 12'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpft_pkg::CFG_MPP_X:        cfg_reg.mpp_x        <= cfg_data;
                bpft_pkg::CFG_MPP_Y:        cfg_reg.mpp_y        <= cfg_data;
                bpft_pkg::CFG_PPM_X:        cfg_reg.ppm_x        <= cfg_data;
                bpft_pkg::CFG_PPM_Y:        cfg_reg.ppm_y        <= cfg_data;
                bpft_pkg::CFG_ORIGIN_X:     cfg_reg.origin_x     <= $signed(cfg_data);
                bpft_pkg::CFG_ORIGIN_Y:     cfg_reg.origin_y     <= $signed(cfg_data);
                bpft_pkg::CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[11:0];
                bpft_pkg::CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[11:0];
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // advance everything unless a finished word is held by the receiver
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    bpft_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .valid_in  (s_axis_tvalid),
        .req_type  (bpft_pkg::req_t'(s_axis_tuser)),
        .car_x     ($signed(s_axis_tdata[23:0])),
        .car_y     ($signed(s_axis_tdata[47:24])),
        .car_yaw   ($signed(s_axis_tdata[67:48])),
        .point_x   ($signed(s_axis_tdata[91:68])),
        .point_y   ($signed(s_axis_tdata[115:92])),
        .point_yaw ($signed(s_axis_tdata[135:116])),
        .pixel_x   ($signed(s_axis_tdata[155:136])),
        .pixel_y   ($signed(s_axis_tdata[175:156])),
        .valid_out (chain_valid[0]),
        .x_out     (chain_x[0]),
        .y_out     (chain_y[0]),
        .z_out     (chain_z[0]),
        .side_out  (chain_side[0])
    );

    // row of CORDIC cells, one micro-rotation each
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        bpft_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage     (bpft_pkg::STAGE_W'(i)),
            .valid_in  (chain_valid[i]),
            .x_in      (chain_x[i]),
            .y_in      (chain_y[i]),
            .z_in      (chain_z[i]),
            .side_in   (chain_side[i]),
            .valid_out (chain_valid[i+1]),
            .x_out     (chain_x[i+1]),
            .y_out     (chain_y[i+1]),
            .z_out     (chain_z[i+1]),
            .side_out  (chain_side[i+1])
        );
    end

    bpft_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .valid_in  (chain_valid[N]),
        .x_in      (chain_x[N]),
        .y_in      (chain_y[N]),
        .side_in   (chain_side[N]),
        .valid_out (out_valid),
        .res_out   (res)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {1'b0, res.saturated, res.row_beyond_image, res.inside_image,
                            res.res_row, res.res_col, res.res_yaw, res.res_y, res.res_x};

endmodule

>>> sv/bpft_cordic_cell.sv
// ----------------------------------------------------------------------------
// bpft_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotates x/y by the stage's arctangent and hands the word to the next cell.
// ----------------------------------------------------------------------------
module bpft_cordic_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [bpft_pkg::STAGE_W-1:0]      stage,
    input  logic                              valid_in,
    input  logic signed [bpft_pkg::XW-1:0]    x_in,
    input  logic signed [bpft_pkg::XW-1:0]    y_in,
    input  logic signed [bpft_pkg::ZW-1:0]    z_in,
    input  bpft_pkg::side_t                   side_in,
    output logic                              valid_out,
    output logic signed [bpft_pkg::XW-1:0]    x_out,
    output logic signed [bpft_pkg::XW-1:0]    y_out,
    output logic signed [bpft_pkg::ZW-1:0]    z_out,
    output bpft_pkg::side_t                   side_out
);

    logic                           valid_reg;
    logic signed [bpft_pkg::XW-1:0] x_reg, x_next;
    logic signed [bpft_pkg::XW-1:0] y_reg, y_next;
    logic signed [bpft_pkg::ZW-1:0] z_reg, z_next;
    bpft_pkg::side_t                side_reg;
    logic signed [bpft_pkg::XW-1:0] x_sh, y_sh;
    logic signed [bpft_pkg::ZW-1:0] ang;

    assign x_sh = x_in >>> stage;
    assign y_sh = y_in >>> stage;
    assign ang  = bpft_pkg::atan_q30(5'(stage));

    always_comb
    begin
        if (!z_in[bpft_pkg::ZW-1])
        begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - ang;
        end
        else
        begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

>>> sv/bpft_front.sv
// ----------------------------------------------------------------------------
// bpft_front: request capture and preparation
// Registers the request, folds the yaw for CORDIC, scales pixels to metres,
// forms the operand pair and wraps the result heading.
// ----------------------------------------------------------------------------
module bpft_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  bpft_pkg::cfg_t                 cfg,
    input  logic                           valid_in,
    input  bpft_pkg::req_t                 req_type,
    input  logic signed [23:0]             car_x,
    input  logic signed [23:0]             car_y,
    input  logic signed [19:0]             car_yaw,
    input  logic signed [23:0]             point_x,
    input  logic signed [23:0]             point_y,
    input  logic signed [19:0]             point_yaw,
    input  logic signed [19:0]             pixel_x,
    input  logic signed [19:0]             pixel_y,
    output logic                           valid_out,
    output logic signed [bpft_pkg::XW-1:0] x_out,
    output logic signed [bpft_pkg::XW-1:0] y_out,
    output logic signed [bpft_pkg::ZW-1:0] z_out,
    output bpft_pkg::side_t                side_out
);

    // capture stage
    logic               a_valid_reg;
    bpft_pkg::req_t     a_req_reg;
    logic signed [23:0] a_car_x_reg, a_car_y_reg, a_point_x_reg, a_point_y_reg;
    logic signed [19:0] a_car_yaw_reg, a_point_yaw_reg, a_pixel_x_reg, a_pixel_y_reg;

    // preparation stage
    logic                           b_valid_reg;
    logic signed [bpft_pkg::ZW-1:0] b_z_reg;
    bpft_pkg::side_t                b_side_reg, b_side_next;

    logic signed [35:0] z_full, z_w1, z_w2, z_f;
    logic               flip;
    logic signed [44:0] prod_x, prod_y;
    logic signed [39:0] cx, cy;
    logic signed [23:0] px_sat, py_sat;
    logic signed [21:0] yaw_sum, yaw_mod;

    function automatic logic signed [21:0] trunc_mod(input logic signed [21:0] s);
        logic signed [21:0] r;
        r = s;
        if (s >= bpft_pkg::FOUR_PI_Q16)
            r = s - bpft_pkg::FOUR_PI_Q16;
        else if (s >= bpft_pkg::TWO_PI_Q16)
            r = s - bpft_pkg::TWO_PI_Q16;
        else if (s <= -bpft_pkg::FOUR_PI_Q16)
            r = s + bpft_pkg::FOUR_PI_Q16;
        else if (s <= -bpft_pkg::TWO_PI_Q16)
            r = s + bpft_pkg::TWO_PI_Q16;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= valid_in;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_req_reg       <= req_type;
            a_car_x_reg     <= car_x;
            a_car_y_reg     <= car_y;
            a_car_yaw_reg   <= car_yaw;
            a_point_x_reg   <= point_x;
            a_point_y_reg   <= point_y;
            a_point_yaw_reg <= point_yaw;
            a_pixel_x_reg   <= pixel_x;
            a_pixel_y_reg   <= pixel_y;
            b_z_reg         <= z_f[bpft_pkg::ZW-1:0];
            b_side_reg      <= b_side_next;
        end
    end

    // fold the heading into [-pi/2, pi/2], remember the half-turn
    always_comb
    begin
        z_full = {{2{a_car_yaw_reg[19]}}, a_car_yaw_reg, 14'b0};
        z_w1   = (z_full > bpft_pkg::PI_Q30) ? z_full - bpft_pkg::TWO_PI_Q30 : z_full;
        z_w2   = (z_w1 < -bpft_pkg::PI_Q30) ? z_w1 + bpft_pkg::TWO_PI_Q30 : z_w1;
        flip   = 1'b0;
        z_f    = z_w2;
        if (z_w2 > bpft_pkg::HALF_PI_Q30)
        begin
            z_f  = z_w2 - bpft_pkg::PI_Q30;
            flip = 1'b1;
        end
        else if (z_w2 < -bpft_pkg::HALF_PI_Q30)
        begin
            z_f  = z_w2 + bpft_pkg::PI_Q30;
            flip = 1'b1;
        end
    end

    // pixel to car frame
    assign prod_y = a_pixel_y_reg * $signed({1'b0, cfg.mpp_y});
    assign prod_x = a_pixel_x_reg * $signed({1'b0, cfg.mpp_x});
    assign cx     = 40'(cfg.origin_x) - 40'((prod_y + 45'sd2048) >>> 12);
    assign cy     = 40'(cfg.origin_y) - 40'((prod_x + 45'sd2048) >>> 12);
    assign px_sat = bpft_pkg::sat24(cx);
    assign py_sat = bpft_pkg::sat24(cy);

    always_comb
    begin
        b_side_next        = '0;
        b_side_next.req    = a_req_reg;
        b_side_next.car_x  = a_car_x_reg;
        b_side_next.car_y  = a_car_y_reg;
        b_side_next.flip   = flip;
        yaw_sum            = '0;
        yaw_mod            = '0;
        case (a_req_reg)
            bpft_pkg::REQ_CAR_TO_WORLD:
            begin
                b_side_next.u = 25'(a_point_x_reg);
                b_side_next.v = 25'(a_point_y_reg);
                yaw_sum       = 22'(a_point_yaw_reg) + 22'(a_car_yaw_reg);
                yaw_mod       = trunc_mod(yaw_sum);
            end
            bpft_pkg::REQ_PIXEL_TO_WORLD:
            begin
                b_side_next.u      = 25'(px_sat);
                b_side_next.v      = 25'(py_sat);
                b_side_next.satf   = (40'(px_sat) != cx) || (40'(py_sat) != cy);
                b_side_next.beyond = 22'(a_pixel_y_reg) >
                                     $signed({6'b0, cfg.image_height, 4'b0});
                yaw_sum            = 22'(a_car_yaw_reg);
                yaw_mod            = trunc_mod(yaw_sum);
            end
            bpft_pkg::REQ_WORLD_TO_CAR:
            begin
                b_side_next.u = 25'(a_point_x_reg) - 25'(a_car_x_reg);
                b_side_next.v = 25'(a_point_y_reg) - 25'(a_car_y_reg);
                yaw_sum       = 22'(a_point_yaw_reg) - 22'(a_car_yaw_reg);
                yaw_mod       = trunc_mod(yaw_sum);
                if (yaw_mod < 0)
                    yaw_mod = yaw_mod + bpft_pkg::TWO_PI_Q16;
            end
            default:
            begin
                b_side_next.u = 25'(a_point_x_reg) - 25'(a_car_x_reg);
                b_side_next.v = 25'(a_point_y_reg) - 25'(a_car_y_reg);
            end
        endcase
        b_side_next.yaw = yaw_mod[19:0];
    end

    assign valid_out = b_valid_reg;
    assign x_out     = bpft_pkg::GAIN_Q30;
    assign y_out     = '0;
    assign z_out     = b_z_reg;
    assign side_out  = b_side_reg;

endmodule

>>> sv/bpft_back.sv
// ----------------------------------------------------------------------------
// bpft_back: rotation, translation, pixel scaling and result register
// Four stages: products, sums and clipping, metre-to-pixel products, flags.
// ----------------------------------------------------------------------------
module bpft_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  bpft_pkg::cfg_t                 cfg,
    input  logic                           valid_in,
    input  logic signed [bpft_pkg::XW-1:0] x_in,
    input  logic signed [bpft_pkg::XW-1:0] y_in,
    input  bpft_pkg::side_t                side_in,
    output logic                           valid_out,
    output bpft_pkg::res_t                 res_out
);

    logic signed [bpft_pkg::XW-1:0] c, s;

    // stage 1: rotation products
    logic               m1_valid_reg;
    bpft_pkg::side_t    m1_side_reg;
    logic signed [58:0] m1_uc_reg, m1_us_reg, m1_vc_reg, m1_vs_reg;

    // stage 2: sums, translation, clipping
    logic               m2_valid_reg;
    bpft_pkg::req_t     m2_req_reg;
    logic signed [23:0] m2_x_reg, m2_x_next, m2_y_reg, m2_y_next;
    logic signed [19:0] m2_yaw_reg;
    logic               m2_beyond_reg, m2_satf_reg, m2_satf_next;
    logic signed [32:0] m2_t1_reg, m2_t1_next, m2_t2_reg, m2_t2_next;
    logic signed [59:0] sx, sy;
    logic signed [39:0] rsx, rsy, ax, ay;

    // stage 3: metre-to-pixel products
    logic               m3_valid_reg;
    bpft_pkg::req_t     m3_req_reg;
    logic signed [23:0] m3_x_reg, m3_y_reg;
    logic signed [19:0] m3_yaw_reg;
    logic               m3_beyond_reg, m3_satf_reg;
    logic signed [57:0] m3_pc_reg, m3_pr_reg;

    // stage 4: result register
    logic               out_valid_reg;
    bpft_pkg::res_t     out_reg, out_next;
    logic signed [39:0] cu, ru;
    logic signed [19:0] col_sat, row_sat;

    assign c = side_in.flip ? -x_in : x_in;
    assign s = side_in.flip ? -y_in : y_in;

    always_comb
    begin
        if (m1_side_reg.req == bpft_pkg::REQ_CAR_TO_WORLD ||
            m1_side_reg.req == bpft_pkg::REQ_PIXEL_TO_WORLD)
        begin
            sx = 60'(m1_uc_reg) - 60'(m1_vs_reg);
            sy = 60'(m1_us_reg) + 60'(m1_vc_reg);
        end
        else
        begin
            sx = 60'(m1_uc_reg) + 60'(m1_vs_reg);
            sy = 60'(m1_vc_reg) - 60'(m1_us_reg);
        end
        rsx = 40'((sx + 60'sd536870912) >>> 30);
        rsy = 40'((sy + 60'sd536870912) >>> 30);
        ax  = rsx + 40'(m1_side_reg.car_x);
        ay  = rsy + 40'(m1_side_reg.car_y);
        m2_x_next    = '0;
        m2_y_next    = '0;
        m2_satf_next = m1_side_reg.satf;
        m2_t1_next   = 33'(cfg.origin_y) - 33'(rsy);
        m2_t2_next   = 33'(cfg.origin_x) - 33'(rsx);
        unique case (m1_side_reg.req)
            bpft_pkg::REQ_CAR_TO_WORLD, bpft_pkg::REQ_PIXEL_TO_WORLD:
            begin
                m2_x_next    = bpft_pkg::sat24(ax);
                m2_y_next    = bpft_pkg::sat24(ay);
                m2_satf_next = m1_side_reg.satf || (40'(m2_x_next) != ax) ||
                               (40'(m2_y_next) != ay);
            end
            bpft_pkg::REQ_WORLD_TO_CAR:
            begin
                m2_x_next    = bpft_pkg::sat24(rsx);
                m2_y_next    = bpft_pkg::sat24(rsy);
                m2_satf_next = (40'(m2_x_next) != rsx) || (40'(m2_y_next) != rsy);
            end
            default:
            begin
                m2_x_next = '0;
                m2_y_next = '0;
            end
        endcase
    end

    // stage 4: scale back to pixels, check bounds
    always_comb
    begin
        cu      = 40'((m3_pc_reg + 58'sd524288) >>> 20);
        ru      = 40'((m3_pr_reg + 58'sd524288) >>> 20);
        col_sat = bpft_pkg::sat20(cu);
        row_sat = bpft_pkg::sat20(ru);
        out_next                  = '0;
        out_next.res_x            = m3_x_reg;
        out_next.res_y            = m3_y_reg;
        out_next.res_yaw          = m3_yaw_reg;
        out_next.row_beyond_image = m3_beyond_reg;
        out_next.saturated        = m3_satf_reg;
        if (m3_req_reg == bpft_pkg::REQ_WORLD_TO_PIXEL)
        begin
            out_next.res_col      = col_sat;
            out_next.res_row      = row_sat;
            out_next.saturated    = (40'(col_sat) != cu) || (40'(row_sat) != ru);
            out_next.inside_image = (cu >= 0) && (cu < $signed({24'b0, cfg.image_width, 4'b0})) &&
                                    (ru >= 0) && (ru < $signed({24'b0, cfg.image_height, 4'b0}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg  <= valid_in;
            m2_valid_reg  <= m1_valid_reg;
            m3_valid_reg  <= m2_valid_reg;
            out_valid_reg <= m3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_side_reg   <= side_in;
            m1_uc_reg     <= side_in.u * c;
            m1_us_reg     <= side_in.u * s;
            m1_vc_reg     <= side_in.v * c;
            m1_vs_reg     <= side_in.v * s;
            m2_req_reg    <= m1_side_reg.req;
            m2_x_reg      <= m2_x_next;
            m2_y_reg      <= m2_y_next;
            m2_yaw_reg    <= m1_side_reg.yaw;
            m2_beyond_reg <= m1_side_reg.beyond;
            m2_satf_reg   <= m2_satf_next;
            m2_t1_reg     <= m2_t1_next;
            m2_t2_reg     <= m2_t2_next;
            m3_req_reg    <= m2_req_reg;
            m3_x_reg      <= m2_x_reg;
            m3_y_reg      <= m2_y_reg;
            m3_yaw_reg    <= m2_yaw_reg;
            m3_beyond_reg <= m2_beyond_reg;
            m3_satf_reg   <= m2_satf_reg;
            m3_pc_reg     <= m2_t1_reg * $signed({1'b0, cfg.ppm_x});
            m3_pr_reg     <= m2_t2_reg * $signed({1'b0, cfg.ppm_y});
            out_reg       <= out_next;
        end
    end

    assign valid_out = out_valid_reg;
    assign res_out   = out_reg;

    a_inside_not_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.inside_image |-> !out_reg.saturated)
        else $error("inside_image set on a clipped pixel");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.inside_image && out_reg.row_beyond_image))
        else $error("inside_image and row_beyond_image both set");

    a_word_advances: assert property (@(posedge clk) disable iff (!rst_n)
        en && m3_valid_reg |=> out_valid_reg)
        else $error("word lost between last stage and result register");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for birdview_pose_frame_transform
// Streams requests of all four kinds through the block under several register
// settings and idling patterns, predicts every result word in the bench and
// compares each returned word field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = bpft_pkg::CORDIC_STAGES + 16;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 330;

    typedef struct {
        bpft_pkg::req_t     req;
        logic signed [23:0] car_x, car_y;
        logic signed [19:0] car_yaw;
        logic signed [23:0] point_x, point_y;
        logic signed [19:0] point_yaw;
        logic signed [19:0] pixel_x, pixel_y;
    } pose_req_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic [175:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;

    pose_req_t      pending_reqs[$];
    bpft_pkg::res_t expected_res[$];
    bpft_pkg::cfg_t shadow_cfg;
    int             errors = 0;
    int             cycles = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    bit             req_taken = 1'b0;

    birdview_pose_frame_transform dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Clip to a signed field of w bits, raising the flag on a clip
    function automatic longint clip(longint v, int w, inout bit flag);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        if (v > hi)
        begin
            flag = 1'b1;
            return hi;
        end
        if (v < -hi - 1)
        begin
            flag = 1'b1;
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic longint rshift_round(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // Work out the result word for one request under the current registers
    function automatic bpft_pkg::res_t transform_pose(pose_req_t it, bpft_pkg::cfg_t cf);
        longint cx, cy, cyaw, px, py, pyaw, pxl, pyl;
        longint z, x, y, nx, c, s;
        longint rx, ry, ryaw, col, row, dx, dy, xc, yc, cu, ru;
        bit     flip, satf, in_img, beyond;
        bpft_pkg::res_t r;
        cx = it.car_x; cy = it.car_y; cyaw = it.car_yaw;
        px = it.point_x; py = it.point_y; pyaw = it.point_yaw;
        pxl = it.pixel_x; pyl = it.pixel_y;
        rx = 0; ry = 0; ryaw = 0; col = 0; row = 0;
        satf = 0; in_img = 0; beyond = 0; flip = 0;
        // fold the yaw into [-pi/2, pi/2], then rotate the gain vector
        z = cyaw * 16384;
        x = bpft_pkg::GAIN_Q30;
        y = 0;
        if (z > bpft_pkg::PI_Q30) z -= bpft_pkg::TWO_PI_Q30;
        if (z < -bpft_pkg::PI_Q30) z += bpft_pkg::TWO_PI_Q30;
        if (z > bpft_pkg::HALF_PI_Q30)
        begin
            z -= bpft_pkg::PI_Q30;
            flip = 1;
        end
        else if (z < -bpft_pkg::HALF_PI_Q30)
        begin
            z += bpft_pkg::PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < bpft_pkg::CORDIC_STAGES && i < 32; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= longint'(bpft_pkg::ATAN_Q30[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += longint'(bpft_pkg::ATAN_Q30[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;

        if (it.req == bpft_pkg::REQ_CAR_TO_WORLD || it.req == bpft_pkg::REQ_PIXEL_TO_WORLD)
        begin
            if (it.req == bpft_pkg::REQ_PIXEL_TO_WORLD)
            begin
                px = clip(longint'(cf.origin_x)
                          - rshift_round(pyl * longint'(cf.mpp_y), 12), 24, satf);
                py = clip(longint'(cf.origin_y)
                          - rshift_round(pxl * longint'(cf.mpp_x), 12), 24, satf);
                pyaw = 0;
                beyond = pyl > longint'(cf.image_height) * 16;
            end
            rx = clip(rshift_round(px * c - py * s, 30) + cx, 24, satf);
            ry = clip(rshift_round(px * s + py * c, 30) + cy, 24, satf);
            ryaw = (pyaw + cyaw) % longint'(bpft_pkg::TWO_PI_Q16);
        end
        else
        begin
            dx = px - cx;
            dy = py - cy;
            xc = rshift_round(dx * c + dy * s, 30);
            yc = rshift_round(dy * c - dx * s, 30);
            if (it.req == bpft_pkg::REQ_WORLD_TO_CAR)
            begin
                rx = clip(xc, 24, satf);
                ry = clip(yc, 24, satf);
                ryaw = (pyaw - cyaw) % longint'(bpft_pkg::TWO_PI_Q16);
                if (ryaw < 0) ryaw += longint'(bpft_pkg::TWO_PI_Q16);
            end
            else
            begin
                cu = rshift_round((longint'(cf.origin_y) - yc) * longint'(cf.ppm_x), 20);
                ru = rshift_round((longint'(cf.origin_x) - xc) * longint'(cf.ppm_y), 20);
                in_img = cu >= 0 && cu < longint'(cf.image_width) * 16 &&
                         ru >= 0 && ru < longint'(cf.image_height) * 16;
                col = clip(cu, 20, satf);
                row = clip(ru, 20, satf);
            end
        end
        r.res_x = 24'(rx); r.res_y = 24'(ry); r.res_yaw = 20'(ryaw);
        r.res_col = 20'(col); r.res_row = 20'(row);
        r.inside_image = in_img; r.row_beyond_image = beyond; r.saturated = satf;
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
    endtask

    // Append one request to the pending queue
    task automatic enqueue_req(pose_req_t item);
        pending_reqs = {pending_reqs, item};
    endtask

    // Mix of full-width patterns, extremes and modest magnitudes
    function automatic longint rand_field(int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        case ($urandom_range(0, 3))
            0: return longint'({$urandom, $urandom});
            1: return $urandom_range(0, 1) ? hi : -hi - 1;
            2: return longint'($urandom_range(0, 65535)) - 32768;
            default: return longint'($urandom_range(0, 2 * 1048575)) - 1048576;
        endcase
    endfunction

    function automatic longint rand_yaw();
        if ($urandom_range(0, 3) != 0)
            return longint'($urandom_range(0, 823548)) - 411774;
        return longint'($urandom);
    endfunction

    function automatic pose_req_t make_req(bpft_pkg::req_t rq, longint cx, longint cy,
                                           longint cyaw, longint px, longint py,
                                           longint pyaw, longint pxl, longint pyl);
        pose_req_t it;
        it.req = rq; it.car_x = 24'(cx); it.car_y = 24'(cy); it.car_yaw = 20'(cyaw);
        it.point_x = 24'(px); it.point_y = 24'(py); it.point_yaw = 20'(pyaw);
        it.pixel_x = 20'(pxl); it.pixel_y = 20'(pyl);
        return it;
    endfunction

    task automatic write_reg(bpft_pkg::cfg_idx_t idx, logic [23:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        // block is idle, so the shadow copy may change at once
        case (idx)
            bpft_pkg::CFG_MPP_X:        shadow_cfg.mpp_x = val;
            bpft_pkg::CFG_MPP_Y:        shadow_cfg.mpp_y = val;
            bpft_pkg::CFG_PPM_X:        shadow_cfg.ppm_x = val;
            bpft_pkg::CFG_PPM_Y:        shadow_cfg.ppm_y = val;
            bpft_pkg::CFG_ORIGIN_X:     shadow_cfg.origin_x = val;
            bpft_pkg::CFG_ORIGIN_Y:     shadow_cfg.origin_y = val;
            bpft_pkg::CFG_IMAGE_WIDTH:  shadow_cfg.image_width = val[11:0];
            bpft_pkg::CFG_IMAGE_HEIGHT: shadow_cfg.image_height = val[11:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [23:0] mx, my, qx, qy, ox, oy, w, h);
        write_reg(bpft_pkg::CFG_MPP_X, mx);
        write_reg(bpft_pkg::CFG_MPP_Y, my);
        write_reg(bpft_pkg::CFG_PPM_X, qx);
        write_reg(bpft_pkg::CFG_PPM_Y, qy);
        write_reg(bpft_pkg::CFG_ORIGIN_X, ox);
        write_reg(bpft_pkg::CFG_ORIGIN_Y, oy);
        write_reg(bpft_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(bpft_pkg::CFG_IMAGE_HEIGHT, h);
    endtask

    // Driver: present the front pending request; hold it until it is taken
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || req_taken)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_reqs[0].req;
                s_axis_tdata  <= {pending_reqs[0].pixel_y, pending_reqs[0].pixel_x,
                                  pending_reqs[0].point_yaw, pending_reqs[0].point_y,
                                  pending_reqs[0].point_x, pending_reqs[0].car_yaw,
                                  pending_reqs[0].car_y, pending_reqs[0].car_x};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end

    // Monitor: predict on every accepted request, check every accepted word
    always @(posedge clk)
    begin
        bpft_pkg::res_t want;
        cycles++;
        req_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_res = {expected_res, transform_pose(pending_reqs[0], shadow_cfg)};
            pending_reqs.pop_front();
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_res.size() == 0)
                report("unexpected result word", 1, 0);
            else
            begin
                want = expected_res.pop_front();
                if ($signed(m_axis_tdata[23:0]) != want.res_x)
                    report("res_x", $signed(m_axis_tdata[23:0]), want.res_x);
                if ($signed(m_axis_tdata[47:24]) != want.res_y)
                    report("res_y", $signed(m_axis_tdata[47:24]), want.res_y);
                if ($signed(m_axis_tdata[67:48]) != want.res_yaw)
                    report("res_yaw", $signed(m_axis_tdata[67:48]), want.res_yaw);
                if ($signed(m_axis_tdata[87:68]) != want.res_col)
                    report("res_col", $signed(m_axis_tdata[87:68]), want.res_col);
                if ($signed(m_axis_tdata[107:88]) != want.res_row)
                    report("res_row", $signed(m_axis_tdata[107:88]), want.res_row);
                if (m_axis_tdata[108] != want.inside_image)
                    report("inside_image", m_axis_tdata[108], want.inside_image);
                if (m_axis_tdata[109] != want.row_beyond_image)
                    report("row_beyond_image", m_axis_tdata[109], want.row_beyond_image);
                if (m_axis_tdata[110] != want.saturated)
                    report("saturated", m_axis_tdata[110], want.saturated);
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** birdview_pose_frame_transform: FAILED **");
            $finish;
        end
    end

    initial
    begin
        pose_req_t it;
        shadow_cfg = '{mpp_x: 24'd41943, mpp_y: 24'd41943,
                       ppm_x: 24'd102400, ppm_y: 24'd102400,
                       origin_x: 24'sd0, origin_y: 24'sd0,
                       image_width: 12'd640, image_height: 12'd480};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // settings: defaults, largest, smallest, zero, then two random
            case (ph)
                0: ;
                1: write_all(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
                             24'h7fffff, 24'h7fffff, 24'hfff, 24'hfff);
                2: write_all(24'd1, 24'd1, 24'd1, 24'd1, 24'h800000, 24'h800000,
                             24'd1, 24'd1);
                3: write_all(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
                default: write_all(24'($urandom_range(1, 200000)),
                                   24'($urandom_range(1, 200000)),
                                   24'($urandom_range(1, 400000)),
                                   24'($urandom_range(1, 400000)),
                                   24'($urandom), 24'($urandom),
                                   24'($urandom_range(1, 4095)),
                                   24'($urandom_range(1, 4095)));
            endcase
            // idling: none, sender idle, receiver stalling, both lightly
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase

            if (ph == 0)
            begin
                // extremes of every field for every kind, yaw folds, row beyond
                for (int k = 0; k < 4; k++)
                begin
                    enqueue_req(make_req(bpft_pkg::req_t'(k), 8388607, 8388607, 411774,
                                8388607, 8388607, 411774, 524287, 524287));
                    enqueue_req(make_req(bpft_pkg::req_t'(k), -8388608, -8388608, -411774,
                                -8388608, -8388608, -411774, -524288, -524288));
                    enqueue_req(make_req(bpft_pkg::req_t'(k), 0, 0, 0, 0, 0, 0, 0, 0));
                    enqueue_req(make_req(bpft_pkg::req_t'(k), 65536, -65536, 102944,
                                131072, 65536, -524288, 4000, 7681));
                    enqueue_req(make_req(bpft_pkg::req_t'(k), -1000, 2000, 524287,
                                300000, -300000, 205887, 16, 7680));
                end
                // a point near the car that lands inside the image
                enqueue_req(make_req(bpft_pkg::REQ_WORLD_TO_PIXEL, 0, 0, 0,
                            -65536, -65536, 0, 0, 0));
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it = make_req(bpft_pkg::req_t'($urandom_range(0, 3)), rand_field(24),
                              rand_field(24), rand_yaw(), rand_field(24), rand_field(24),
                              rand_yaw(), rand_field(20), rand_field(20));
                // keep about half the pixels near the image so row checks flip both ways
                if ($urandom_range(0, 1))
                begin
                    it.pixel_x = 20'(longint'($urandom_range(0, 20 * 4095)) - 4096);
                    it.pixel_y = 20'(longint'($urandom_range(0, 20 * 4095)) - 4096);
                end
                enqueue_req(it);
            end

            wait (pending_reqs.size() == 0 && expected_res.size() == 0);
            repeat (DRAIN_WAIT) @(posedge clk);
        end

        if (errors == 0)
            $display("** birdview_pose_frame_transform: PASSED **");
        else
            $display("** birdview_pose_frame_transform: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
sv/bpft_pkg.sv
sv/bpft_cordic_cell.sv
sv/bpft_front.sv
sv/bpft_back.sv
sv/birdview_pose_frame_transform.sv
tb/testbench.sv
